@@ rtl/ckh_pkg.sv @@
// Package for the coordinate-key chained hash table.
// Holds item and result types, command and status codes, and fixed widths.
// No dependencies.
`default_nettype none

package ckh_pkg;

	// fixed field widths
	localparam int KEY_W     = 16;
	localparam int PAY_W     = 32;
	localparam int CNT_W     = 7;
	localparam int BCNT_W    = 9;
	localparam int CFG_IDX_W = 1;
	// |x*31 + y*37| for 16-bit signed x, y fits in 22 bits
	localparam int ABS_W     = 22;

	// command codes
	localparam logic [1:0] CMD_PUT  = 2'd0;
	localparam logic [1:0] CMD_LOOK = 2'd1;
	localparam logic [1:0] CMD_ALL  = 2'd2;
	localparam logic [1:0] CMD_DUMP = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DUP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BCNT = 1'd1;

	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [KEY_W-1:0] key_x;
		logic signed [KEY_W-1:0] key_y;
		logic [PAY_W-1:0]        payload;
	} item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [KEY_W-1:0] out_x;
		logic signed [KEY_W-1:0] out_y;
		logic [PAY_W-1:0]        out_payload;
		logic [CNT_W-1:0]        match_count;
		logic                    last;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/coordinate_key_chained_hash_table_top.sv @@
// Top level of the coordinate-key chained hash table.
// Depends on ckh_pkg and ckh_mod.
//
// After reset the block sweeps the bucket head memory, one bucket a cycle, with
// busy high. An item is taken when start is high and busy low. Put, lookup and
// lookup-all first pass through the remainder unit (one bit of the 22-bit hash
// magnitude per cycle), then read the bucket head and then each chain node in
// turn, since each node read through the node memory's registered port must
// land before the link is known. A walk that ends without a hit closes in a
// final state. Lookup-all walks the chain twice when the first walk finds a
// match, once to count and once to deliver. A new put then writes the node
// and links it in. Dump reads each bucket head and each stored item in turn; a
// dump of an empty table answers the cycle after it is taken and never raises
// busy. Results come one per strobe and cannot be held off; the last result
// carries last = 1, and busy is already low in the cycle that carries it.
`default_nettype none

module coordinate_key_chained_hash_table_top #(
	parameter int BUCKETS    = 256,
	parameter int NODES      = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire ckh_pkg::item_t                  item,
	output logic                                 result_valid,
	output ckh_pkg::res_t                        result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ckh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ckh_pkg::BCNT_W-1:0]      cfg_data
);

	localparam int NW = $clog2(NODES + 1);
	localparam int AW = $clog2(NODES);
	localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int BW = $clog2(BUCKETS + 1);
	localparam logic [NW-1:0] NIL = NW'(NODES);

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b0000000001,
		S_IDLE     = 10'b0000000010,
		S_HASH     = 10'b0000000100,
		S_HEAD_RD  = 10'b0000001000,
		S_HEAD_CHK = 10'b0000010000,
		S_NODE_RD  = 10'b0000100000,
		S_NODE_CHK = 10'b0001000000,
		S_FIN      = 10'b0010000000,
		S_ALLOC    = 10'b0100000000,
		S_LINK     = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic                        dup_q;
	logic [ckh_pkg::BCNT_W-1:0]  bcnt_q;
	logic [BW-1:0]               divisor;

	// item context
	logic [1:0]                  cmd_q;
	logic [2*ckh_pkg::KEY_W-1:0] key_q;
	logic [VALUE_BITS-1:0]       pay_q;
	logic [HW-1:0]               h_q;
	logic [HW-1:0]               bkt_q;
	logic [HW-1:0]               clr_q;
	logic [NW-1:0]               cur_q;
	logic [NW-1:0]               prev_q;
	logic [NW-1:0]               steps_q;
	logic [NW-1:0]               mcnt_q;
	logic [NW-1:0]               emit_q;
	logic                        pass2_q;
	logic [NW-1:0]               item_cnt_q;

	// memories
	logic [NW-1:0]               head_mem [BUCKETS];
	logic [2*ckh_pkg::KEY_W-1:0] key_mem  [NODES];
	logic [VALUE_BITS-1:0]       val_mem  [NODES];
	logic [NW-1:0]               link_mem [NODES];

	logic                        head_we;
	logic [HW-1:0]               head_wa;
	logic [NW-1:0]               head_wd;
	logic [HW-1:0]               head_ra;
	logic [NW-1:0]               head_rd_q;
	logic                        key_we;
	logic                        val_we;
	logic [AW-1:0]               val_wa;
	logic [VALUE_BITS-1:0]       val_wd;
	logic                        link_we;
	logic [AW-1:0]               link_wa;
	logic [NW-1:0]               link_wd;
	logic [AW-1:0]               node_ra;
	logic [2*ckh_pkg::KEY_W-1:0] key_rd_q;
	logic [VALUE_BITS-1:0]       val_rd_q;
	logic [NW-1:0]               link_rd_q;

	// hash
	logic signed [23:0]          hsum;
	logic [23:0]                 habs;
	logic                        mod_start;
	logic                        mod_done;
	logic [BW-1:0]               mod_rem;

	logic                        accept;
	logic                        match;
	logic                        full;
	logic                        last_all;
	logic                        last_dump;
	logic                        walk_more;
	logic                        last_bkt;
	logic [63:0]                 pay_ext;
	logic [63:0]                 val_ext;
	logic [ckh_pkg::PAY_W-1:0]   val_out;
	logic [NW-1:0]               steps_nx;

	ckh_pkg::res_t               res_q;
	logic                        res_valid_q;

	assign accept    = (state_q == S_IDLE) && start;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// clamp the bucket count into 1..BUCKETS
	always_comb begin
		if (bcnt_q == '0)
			divisor = BW'(1);
		else if (32'(bcnt_q) > BUCKETS)
			divisor = BW'(BUCKETS);
		else
			divisor = BW'(bcnt_q);
	end

	// hash magnitude, then the remainder unit takes the modulo
	assign hsum = 24'(item.key_x) * 24'sd31 + 24'(item.key_y) * 24'sd37;
	assign habs = hsum[23] ? 24'(-hsum) : 24'(hsum);
	assign mod_start = accept && (item.cmd != ckh_pkg::CMD_DUMP);

	ckh_mod #(.BW(BW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (habs[ckh_pkg::ABS_W-1:0]),
		.divisor  (divisor),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// payload width adaption
	assign pay_ext = 64'(item.payload);
	assign val_ext = 64'(val_rd_q);
	assign val_out = val_ext[ckh_pkg::PAY_W-1:0];

	assign match     = (key_rd_q == key_q);
	assign full      = (32'(item_cnt_q) == NODES);
	assign last_all  = (emit_q + 1'b1 == mcnt_q);
	assign last_dump = (emit_q + 1'b1 == item_cnt_q);
	assign steps_nx  = steps_q + 1'b1;
	assign walk_more = (link_rd_q < NIL) && (steps_nx < NIL);
	assign last_bkt  = (32'(bkt_q) == BUCKETS - 1);

	// memory controls
	always_comb begin
		head_we = 1'b0;
		head_wa = clr_q;
		head_wd = NIL;
		key_we  = 1'b0;
		val_we  = 1'b0;
		val_wa  = cur_q[AW-1:0];
		val_wd  = pay_q;
		link_we = 1'b0;
		link_wa = prev_q[AW-1:0];
		link_wd = item_cnt_q;
		head_ra = (cmd_q == ckh_pkg::CMD_DUMP) ? bkt_q : h_q;
		node_ra = cur_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				head_we = 1'b1;
			end
			S_NODE_CHK: begin
				if (cmd_q == ckh_pkg::CMD_PUT && !dup_q && match)
					val_we = 1'b1;
			end
			S_ALLOC: begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				val_wa  = item_cnt_q[AW-1:0];
				link_we = 1'b1;
				link_wa = item_cnt_q[AW-1:0];
				link_wd = NIL;
			end
			S_LINK: begin
				if (prev_q == NIL) begin
					head_we = 1'b1;
					head_wa = h_q;
					head_wd = item_cnt_q;
				end else begin
					link_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
	end

	// node memories
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[item_cnt_q[AW-1:0]] <= key_q;
		if (val_we)
			val_mem[val_wa] <= val_wd;
		if (link_we)
			link_mem[link_wa] <= link_wd;
		key_rd_q  <= key_mem[node_ra];
		val_rd_q  <= val_mem[node_ra];
		link_rd_q <= link_mem[node_ra];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q  <= 1'b0;
			bcnt_q <= ckh_pkg::BCNT_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ckh_pkg::REG_DUP:  dup_q  <= cfg_data[0];
				ckh_pkg::REG_BCNT: bcnt_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.cmd;
			key_q <= {item.key_y, item.key_x};
			pay_q <= pay_ext[VALUE_BITS-1:0];
		end
		if (state_q == S_HASH && mod_done)
			h_q <= mod_rem[HW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			bkt_q       <= '0;
			cur_q       <= NIL;
			prev_q      <= NIL;
			steps_q     <= '0;
			mcnt_q      <= '0;
			emit_q      <= '0;
			pass2_q     <= 1'b0;
			item_cnt_q  <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == BUCKETS - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						mcnt_q  <= '0;
						emit_q  <= '0;
						pass2_q <= 1'b0;
						bkt_q   <= '0;
						if (item.cmd != ckh_pkg::CMD_DUMP) begin
							state_q <= S_HASH;
						end else if (item_cnt_q == '0) begin
							res_valid_q <= 1'b1;
							res_q       <= '{ckh_pkg::ST_NONE, '0, '0, '0, '0, 1'b1};
						end else begin
							state_q <= S_HEAD_RD;
						end
					end
				end
				S_HASH: begin
					if (mod_done)
						state_q <= S_HEAD_RD;
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_CHK;
				end
				S_HEAD_CHK: begin
					cur_q   <= head_rd_q;
					prev_q  <= NIL;
					steps_q <= '0;
					if (head_rd_q < NIL) begin
						state_q <= S_NODE_RD;
					end else if (cmd_q == ckh_pkg::CMD_DUMP) begin
						bkt_q   <= bkt_q + 1'b1;
						state_q <= last_bkt ? S_IDLE : S_HEAD_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_NODE_RD: begin
					state_q <= S_NODE_CHK;
				end
				S_NODE_CHK: begin
					// advance along the chain unless this node ends the item
					prev_q  <= cur_q;
					cur_q   <= link_rd_q;
					steps_q <= steps_nx;
					state_q <= walk_more ? S_NODE_RD : S_FIN;
					case (cmd_q)
						ckh_pkg::CMD_PUT: begin
							if (match && !dup_q) begin
								res_valid_q <= 1'b1;
								res_q <= '{ckh_pkg::ST_OK, key_q[15:0], key_q[31:16],
									'0, '0, 1'b1};
								state_q <= S_IDLE;
							end
						end
						ckh_pkg::CMD_LOOK: begin
							if (match) begin
								res_valid_q <= 1'b1;
								res_q <= '{ckh_pkg::ST_OK, key_q[15:0], key_q[31:16],
									val_out, '0, 1'b1};
								state_q <= S_IDLE;
							end
						end
						ckh_pkg::CMD_ALL: begin
							if (match && !pass2_q) begin
								mcnt_q <= mcnt_q + 1'b1;
							end else if (match) begin
								emit_q      <= emit_q + 1'b1;
								res_valid_q <= 1'b1;
								res_q <= '{ckh_pkg::ST_OK, key_q[15:0], key_q[31:16],
									val_out, ckh_pkg::CNT_W'(mcnt_q), last_all};
								if (last_all)
									state_q <= S_IDLE;
							end
						end
						default: begin
							// dump: deliver every node, bucket by bucket
							emit_q      <= emit_q + 1'b1;
							res_valid_q <= 1'b1;
							res_q <= '{ckh_pkg::ST_OK, key_rd_q[15:0], key_rd_q[31:16],
								val_out, ckh_pkg::CNT_W'(item_cnt_q), last_dump};
							if (last_dump) begin
								state_q <= S_IDLE;
							end else if (link_rd_q < NIL) begin
								state_q <= S_NODE_RD;
							end else begin
								bkt_q   <= bkt_q + 1'b1;
								state_q <= last_bkt ? S_IDLE : S_HEAD_RD;
							end
						end
					endcase
				end
				S_FIN: begin
					state_q <= S_IDLE;
					case (cmd_q)
						ckh_pkg::CMD_PUT: begin
							if (full) begin
								res_valid_q <= 1'b1;
								res_q <= '{ckh_pkg::ST_FULL, key_q[15:0], key_q[31:16],
									'0, '0, 1'b1};
							end else begin
								state_q <= S_ALLOC;
							end
						end
						ckh_pkg::CMD_ALL: begin
							if (mcnt_q == '0) begin
								res_valid_q <= 1'b1;
								res_q <= '{ckh_pkg::ST_NONE, key_q[15:0], key_q[31:16],
									'0, '0, 1'b1};
							end else if (!pass2_q) begin
								// walk again and deliver the matches
								pass2_q <= 1'b1;
								state_q <= S_HEAD_RD;
							end
						end
						default: begin
							res_valid_q <= 1'b1;
							res_q <= '{ckh_pkg::ST_NONE, key_q[15:0], key_q[31:16],
								'0, '0, 1'b1};
						end
					endcase
				end
				S_ALLOC: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					item_cnt_q  <= item_cnt_q + 1'b1;
					res_valid_q <= 1'b1;
					res_q <= '{ckh_pkg::ST_OK, key_q[15:0], key_q[31:16], '0, '0, 1'b1};
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// the node pool never holds more than NODES items
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= NIL)
		else $error("item count above pool size");

	// a full status only when the pool is exhausted
	a_full_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ckh_pkg::ST_FULL) |-> full)
		else $error("full reported with free nodes");

	// results follow an accepted item
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy || start))
		else $error("result without an item");

	// no results during the head sweep
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !result_valid)
		else $error("result during head sweep");

endmodule

`default_nettype wire

@@ rtl/ckh_mod.sv @@
// Iterative remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on ckh_pkg for the dividend width.
`default_nettype none

module ckh_mod #(
	parameter int BW = 9
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ckh_pkg::ABS_W-1:0]  dividend,
	input  wire logic [BW-1:0]              divisor,
	output logic                            done,
	output logic [BW-1:0]                   rem
);

	localparam int SW = $clog2(ckh_pkg::ABS_W + 1);

	logic                      run_q;
	logic                      done_q;
	logic [SW-1:0]             step_q;
	logic [ckh_pkg::ABS_W-1:0] dvd_q;
	logic [BW-1:0]             div_q;
	logic [BW-1:0]             rem_q;
	logic [BW:0]               trial;
	logic [BW:0]               diff;
	logic                      ge;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[ckh_pkg::ABS_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(ckh_pkg::ABS_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[BW-1:0] : trial[BW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire
